/* rtl/rfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants of the rotating filter scatter engine
// Sizes, register indexes, command/result records and clamp helpers.
// ----------------------------------------------------------------------------
package rfs_pkg;

   // design limits
   localparam int MAX_ROTATIONS = 8;
   localparam int MAX_ENTRIES   = 128;
   localparam int MAX_PLANES    = 1024;
   localparam int MAX_ORIENT    = 8;
   localparam int MAX_KERNEL    = 4;
   localparam int TABLE_DEPTH   = 1024;

   // derived widths
   localparam int ROT_W    = $clog2(MAX_ROTATIONS + 1);
   localparam int ENT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int ECNT_W   = $clog2(MAX_ENTRIES);
   localparam int PLANE_W  = $clog2(MAX_PLANES + 1);
   localparam int PCNT_W   = $clog2(MAX_PLANES);
   localparam int TAB_AW   = $clog2(TABLE_DEPTH);
   localparam int TAB_DW   = 8;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = 30;
   localparam int STRIDE_W = PLANE_W + ENT_W;
   localparam int SPAN_W   = STRIDE_W + ROT_W;

   // register field widths
   localparam int CFG_PLANE_W  = 11;
   localparam int CFG_ORIENT_W = 4;
   localparam int CFG_KERNEL_W = 3;
   localparam int CFG_ROT_W    = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OUT_PLANES    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_PLANES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIENTATIONS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATIONS     = 3'd5;

   // request function codes
   localparam logic FUNC_TABLE  = 1'b0;
   localparam logic FUNC_WEIGHT = 1'b1;

   // effective configuration after clamping
   typedef struct packed {
      logic [PLANE_W-1:0] op;
      logic [PLANE_W-1:0] ip;
      logic [ROT_W-1:0]   rot;
      logic [ENT_W-1:0]   ent;
   } cfg_type;

   // command from the front to the back
   typedef struct packed {
      logic                is_weight;
      logic [TAB_AW-1:0]   tab_addr;
      logic [TAB_DW-1:0]   tab_value;
      logic [WORD_W-1:0]   word;
      logic [ADDR_W-1:0]   base;
      logic [STRIDE_W-1:0] stride;
      logic [TAB_AW-1:0]   tpos;
      logic [ROT_W-1:0]    rot;
      logic [ENT_W-1:0]    ent;
      logic                bank_end;
   } cmd_type;

   // one result
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] word;
      logic              last_run;
      logic              bad;
      logic              last_bank;
   } rsp_type;

   // plane count clamped to 1..MAX_PLANES
   function automatic logic [PLANE_W-1:0] clamp_planes(input logic [CFG_PLANE_W-1:0] v);
      logic [PLANE_W-1:0] r;
      if (v == '0) r = PLANE_W'(1);
      else if (int'(v) > MAX_PLANES) r = PLANE_W'(MAX_PLANES);
      else r = PLANE_W'(v);
      return r;
   endfunction

   // rotation count clamped to 1..MAX_ROTATIONS
   function automatic logic [ROT_W-1:0] clamp_rot(input logic [CFG_ROT_W-1:0] v);
      logic [ROT_W-1:0] r;
      if (v == '0) r = ROT_W'(1);
      else if (int'(v) > MAX_ROTATIONS) r = ROT_W'(MAX_ROTATIONS);
      else r = ROT_W'(v);
      return r;
   endfunction

   // entries per plane pair: orientations * rows * columns, clamped
   function automatic logic [ENT_W-1:0] calc_entries(input logic [CFG_ORIENT_W-1:0] o,
                                                     input logic [CFG_KERNEL_W-1:0] h,
                                                     input logic [CFG_KERNEL_W-1:0] w);
      logic [3:0] oc;
      logic [2:0] hc;
      logic [2:0] wc;
      logic [7:0] prod;
      logic [ENT_W-1:0] r;
      oc = (o == '0) ? 4'd1 : ((int'(o) > MAX_ORIENT) ? 4'(MAX_ORIENT) : o);
      hc = (h == '0) ? 3'd1 : ((int'(h) > MAX_KERNEL) ? 3'(MAX_KERNEL) : h);
      wc = (w == '0) ? 3'd1 : ((int'(w) > MAX_KERNEL) ? 3'(MAX_KERNEL) : w);
      prod = 8'(oc) * 8'(hc) * 8'(wc);
      if (int'(prod) > MAX_ENTRIES) r = ENT_W'(MAX_ENTRIES);
      else r = ENT_W'(prod);
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/rfs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_front: request intake and address base calculation
// Takes one request, computes strides and the base address of a weight over
// three multiply steps, keeps the bank position counters, hands a command on.
// ----------------------------------------------------------------------------
module rfs_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire                          req_func,
   input  wire  [rfs_pkg::TAB_AW-1:0]   req_table_addr,
   input  wire  [rfs_pkg::TAB_DW-1:0]   req_table_value,
   input  wire  [rfs_pkg::WORD_W-1:0]   req_weight_word,
   input  rfs_pkg::cfg_type             cfg,
   output logic                         cmd_push,
   output rfs_pkg::cmd_type             cmd_data,
   input  wire                          cmd_full
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_MUL3 = 3'd3;
   localparam logic [2:0] S_SEND = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic                           func_ff, func_in;
   logic [rfs_pkg::TAB_AW-1:0]     taddr_ff, taddr_in;
   logic [rfs_pkg::TAB_DW-1:0]     tval_ff, tval_in;
   logic [rfs_pkg::WORD_W-1:0]     word_ff, word_in;
   logic [rfs_pkg::ENT_W-1:0]      ent_ff, ent_in;
   logic [rfs_pkg::STRIDE_W-1:0]   stride_ff, stride_in;
   logic [rfs_pkg::SPAN_W-1:0]     span_ff, span_in;
   logic [rfs_pkg::ADDR_W-1:0]     ipterm_ff, ipterm_in;
   logic [rfs_pkg::ADDR_W-1:0]     base_ff, base_in;
   logic [rfs_pkg::TAB_AW-1:0]     tpos_ff, tpos_in;
   logic                           bank_ff, bank_in;
   logic [rfs_pkg::PCNT_W-1:0]     opc_ff, opc_in;
   logic [rfs_pkg::PCNT_W-1:0]     ipc_ff, ipc_in;
   logic [rfs_pkg::ECNT_W-1:0]     ec_ff, ec_in;
   logic [rfs_pkg::ENT_W-1:0]      ec_next;
   logic [rfs_pkg::PLANE_W-1:0]    ipc_next;
   logic [rfs_pkg::PLANE_W-1:0]    opc_next;

   assign req_full = (state_ff != S_IDLE);

   // position counters plus one, at the width of their limits
   assign ec_next  = rfs_pkg::ENT_W'(ec_ff) + rfs_pkg::ENT_W'(1);
   assign ipc_next = rfs_pkg::PLANE_W'(ipc_ff) + rfs_pkg::PLANE_W'(1);
   assign opc_next = rfs_pkg::PLANE_W'(opc_ff) + rfs_pkg::PLANE_W'(1);

   // command toward the back
   always_comb begin
      cmd_data.is_weight = (func_ff == rfs_pkg::FUNC_WEIGHT);
      cmd_data.tab_addr  = taddr_ff;
      cmd_data.tab_value = tval_ff;
      cmd_data.word      = word_ff;
      cmd_data.base      = base_ff;
      cmd_data.stride    = stride_ff;
      cmd_data.tpos      = tpos_ff;
      cmd_data.rot       = cfg.rot;
      cmd_data.ent       = ent_ff;
      cmd_data.bank_end  = bank_ff;
   end

   // sequencer and datapath
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      taddr_in  = taddr_ff;
      tval_in   = tval_ff;
      word_in   = word_ff;
      ent_in    = ent_ff;
      stride_in = stride_ff;
      span_in   = span_ff;
      ipterm_in = ipterm_ff;
      base_in   = base_ff;
      tpos_in   = tpos_ff;
      bank_in   = bank_ff;
      opc_in    = opc_ff;
      ipc_in    = ipc_ff;
      ec_in     = ec_ff;
      cmd_push  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_push) begin
               func_in  = req_func;
               taddr_in = req_table_addr;
               tval_in  = req_table_value;
               word_in  = req_weight_word;
               ent_in   = cfg.ent;
               state_in = (req_func == rfs_pkg::FUNC_WEIGHT) ? S_MUL1 : S_SEND;
            end
         end
         // in-plane stride, in-plane term, table row, end of bank
         S_MUL1: begin
            stride_in = rfs_pkg::STRIDE_W'(cfg.ip) * rfs_pkg::STRIDE_W'(ent_ff);
            ipterm_in = rfs_pkg::ADDR_W'(ipc_ff) * rfs_pkg::ADDR_W'(ent_ff);
            tpos_in   = rfs_pkg::TAB_AW'(rfs_pkg::TAB_AW'(ec_ff) * rfs_pkg::TAB_AW'(cfg.rot));
            bank_in   = (ec_next >= ent_ff) && (ipc_next >= cfg.ip) && (opc_next >= cfg.op);
            state_in  = S_MUL2;
         end
         // out-plane stride
         S_MUL2: begin
            span_in  = rfs_pkg::SPAN_W'(cfg.rot) * rfs_pkg::SPAN_W'(stride_ff);
            state_in = S_MUL3;
         end
         // base address, wrapped to the address width
         S_MUL3: begin
            base_in  = rfs_pkg::ADDR_W'(opc_ff) * rfs_pkg::ADDR_W'(span_ff) + ipterm_ff;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = S_IDLE;
               // advance bank position after a weight
               if (func_ff == rfs_pkg::FUNC_WEIGHT) begin
                  if (ec_next >= ent_ff) begin
                     ec_in = '0;
                     if (ipc_next >= cfg.ip) begin
                        ipc_in = '0;
                        opc_in = (opc_next >= cfg.op) ? '0 : rfs_pkg::PCNT_W'(opc_next);
                     end else begin
                        ipc_in = rfs_pkg::PCNT_W'(ipc_next);
                     end
                  end else begin
                     ec_in = rfs_pkg::ECNT_W'(ec_next);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         opc_ff   <= '0;
         ipc_ff   <= '0;
         ec_ff    <= '0;
      end else begin
         state_ff <= state_in;
         opc_ff   <= opc_in;
         ipc_ff   <= ipc_in;
         ec_ff    <= ec_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      taddr_ff  <= taddr_in;
      tval_ff   <= tval_in;
      word_ff   <= word_in;
      ent_ff    <= ent_in;
      stride_ff <= stride_in;
      span_ff   <= span_in;
      ipterm_ff <= ipterm_in;
      base_ff   <= base_in;
      tpos_ff   <= tpos_in;
      bank_ff   <= bank_in;
   end

endmodule
`default_nettype wire

/* rtl/rfs_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_cmd_fifo: two-entry command queue between front and back
// Decouples request intake from the rotation sequencer.
// ----------------------------------------------------------------------------
module rfs_cmd_fifo (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  rfs_pkg::cmd_type  push_data,
   output logic              full,
   input  wire               pop,
   output rfs_pkg::cmd_type  pop_data,
   output logic              empty
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rfs_pkg::cmd_type  mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/rfs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_back: index table and rotation sequencer
// Executes table writes, walks each weight's rotations reading one table entry
// per cycle while the result queue has room; forms target addresses, queues results.
// ----------------------------------------------------------------------------
module rfs_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          cmd_empty,
   input  rfs_pkg::cmd_type             cmd_data,
   output logic                         cmd_pop,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic [rfs_pkg::ADDR_W-1:0]   rsp_target_address,
   output logic [rfs_pkg::WORD_W-1:0]   rsp_value_word,
   output logic                         rsp_last_of_run,
   output logic                         rsp_bad_index,
   output logic                         rsp_last_of_bank
);

   localparam logic B_IDLE = 1'b0;
   localparam logic B_RUN  = 1'b1;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   // index table, contents undefined until written
   logic [rfs_pkg::TAB_DW-1:0]     table_mem [rfs_pkg::TABLE_DEPTH];
   logic [rfs_pkg::TAB_DW-1:0]     rd_data_ff;
   logic                           tab_we;
   logic                           tab_re;

   logic                           state_ff, state_in;
   rfs_pkg::cmd_type               cur_ff, cur_in;
   logic [rfs_pkg::ROT_W-1:0]      k_ff, k_in;
   logic [rfs_pkg::ADDR_W-1:0]     acc_ff, acc_in;
   logic [rfs_pkg::TAB_AW-1:0]     pos_ff, pos_in;
   logic                           pend_ff, pend_in;
   logic [rfs_pkg::ADDR_W-1:0]     pend_acc_ff, pend_acc_in;
   logic                           pend_last_ff, pend_last_in;
   logic [rfs_pkg::WORD_W-1:0]     pend_word_ff, pend_word_in;
   logic                           pend_bank_ff, pend_bank_in;
   logic [rfs_pkg::ENT_W-1:0]      pend_ent_ff, pend_ent_in;

   rfs_pkg::rsp_type               out_mem_ff [OUT_DEPTH];
   rfs_pkg::rsp_type               new_rsp;
   logic [OUT_AW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0]              out_cnt_ff, out_cnt_in;
   logic                           out_pop;
   logic                           issue;
   logic                           bad;

   // command handoff and issue gating
   assign cmd_pop = (state_ff == B_IDLE) && !cmd_empty;
   assign tab_we  = cmd_pop && !cmd_data.is_weight;
   assign issue   = (state_ff == B_RUN) &&
                    ((out_cnt_ff + OUT_CW'(pend_ff)) < OUT_CW'(OUT_DEPTH));
   assign tab_re  = issue;

   // rotation sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      pend_acc_in  = pend_acc_ff;
      pend_last_in = pend_last_ff;
      pend_word_in = pend_word_ff;
      pend_bank_in = pend_bank_ff;
      pend_ent_in  = pend_ent_ff;
      case (state_ff)
         B_IDLE: begin
            if (cmd_pop && cmd_data.is_weight) begin
               cur_in   = cmd_data;
               k_in     = '0;
               acc_in   = cmd_data.base;
               pos_in   = cmd_data.tpos;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (issue) begin
               pend_in      = 1'b1;
               pend_acc_in  = acc_ff;
               pend_last_in = ((k_ff + rfs_pkg::ROT_W'(1)) == cur_ff.rot);
               pend_word_in = cur_ff.word;
               pend_bank_in = cur_ff.bank_end;
               pend_ent_in  = cur_ff.ent;
               k_in         = k_ff + rfs_pkg::ROT_W'(1);
               acc_in       = acc_ff + rfs_pkg::ADDR_W'(cur_ff.stride);
               pos_in       = pos_ff + rfs_pkg::TAB_AW'(1);
               if (pend_last_in) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // address from the table entry read last cycle
   always_comb begin
      bad = (rd_data_ff == '0) || (int'(rd_data_ff) > int'(pend_ent_ff));
      new_rsp.addr      = bad ? pend_acc_ff
                              : pend_acc_ff + rfs_pkg::ADDR_W'(rd_data_ff)
                                - rfs_pkg::ADDR_W'(1);
      new_rsp.word      = pend_word_ff;
      new_rsp.last_run  = pend_last_ff;
      new_rsp.bad       = bad;
      new_rsp.last_bank = pend_bank_ff;
   end

   // result queue
   assign rsp_empty          = (out_cnt_ff == '0);
   assign out_pop            = rsp_pop && !rsp_empty;
   assign rsp_target_address = out_mem_ff[rd_ptr_ff].addr;
   assign rsp_value_word     = out_mem_ff[rd_ptr_ff].word;
   assign rsp_last_of_run    = out_mem_ff[rd_ptr_ff].last_run;
   assign rsp_bad_index      = out_mem_ff[rd_ptr_ff].bad;
   assign rsp_last_of_bank   = out_mem_ff[rd_ptr_ff].last_bank;

   always_comb begin
      wr_ptr_in  = pend_ff ? wr_ptr_ff + OUT_AW'(1) : wr_ptr_ff;
      rd_ptr_in  = out_pop ? rd_ptr_ff + OUT_AW'(1) : rd_ptr_ff;
      out_cnt_in = out_cnt_ff + OUT_CW'(pend_ff) - OUT_CW'(out_pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         pend_ff    <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      pos_ff       <= pos_in;
      pend_acc_ff  <= pend_acc_in;
      pend_last_ff <= pend_last_in;
      pend_word_ff <= pend_word_in;
      pend_bank_ff <= pend_bank_in;
      pend_ent_ff  <= pend_ent_in;
      if (pend_ff) begin
         out_mem_ff[wr_ptr_ff] <= new_rsp;
      end
   end

   // table memory, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (tab_we) begin
         table_mem[cmd_data.tab_addr] <= cmd_data.tab_value;
      end
      if (tab_re) begin
         rd_data_ff <= table_mem[pos_ff];
      end
   end

   // result queue never overfills
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CW'(OUT_DEPTH))
      else $error("result queue overfilled");

   // a pending read always comes from a running weight
   a_pend_src: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == B_RUN))
      else $error("table read without running weight");

   // final rotation ends the run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (issue && pend_last_in) |=> (state_ff == B_IDLE))
      else $error("run did not end after final rotation");

endmodule
`default_nettype wire

/* rtl/rotating_filter_scatter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotating_filter_scatter_top: scatter address engine for rotated filters
// Holds the configuration registers and joins the front, queue and back.
// ----------------------------------------------------------------------------
// the front takes a new request only after handing the last one on, a weight
//   after its three multiply steps; the back reads one table entry per
//   rotation; the command queue lets the two work on different requests
// table write requests pass through the front and are executed by the back
// reset: synchronous; registers go to 1, counters and queues clear,
//   the index table keeps no reset value
module rotating_filter_scatter_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_push,
   output logic                               req_full,
   input  wire                                req_func,
   input  wire  [rfs_pkg::TAB_AW-1:0]         req_table_addr,
   input  wire  [rfs_pkg::TAB_DW-1:0]         req_table_value,
   input  wire  [rfs_pkg::WORD_W-1:0]         req_weight_word,
   output logic                               rsp_empty,
   input  wire                                rsp_pop,
   output logic [rfs_pkg::ADDR_W-1:0]         rsp_target_address,
   output logic [rfs_pkg::WORD_W-1:0]         rsp_value_word,
   output logic                               rsp_last_of_run,
   output logic                               rsp_bad_index,
   output logic                               rsp_last_of_bank,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [rfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [rfs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rfs_pkg::CFG_PLANE_W-1:0]   out_planes_ff, out_planes_in;
   logic [rfs_pkg::CFG_PLANE_W-1:0]   in_planes_ff, in_planes_in;
   logic [rfs_pkg::CFG_ORIENT_W-1:0]  orient_ff, orient_in;
   logic [rfs_pkg::CFG_KERNEL_W-1:0]  kern_h_ff, kern_h_in;
   logic [rfs_pkg::CFG_KERNEL_W-1:0]  kern_w_ff, kern_w_in;
   logic [rfs_pkg::CFG_ROT_W-1:0]     rot_ff, rot_in;
   logic                              csr_write;
   rfs_pkg::cfg_type                  cfg;
   logic                              cmd_push;
   logic                              cmd_full;
   logic                              cmd_pop;
   logic                              cmd_empty;
   rfs_pkg::cmd_type                  cmd_wr_data;
   rfs_pkg::cmd_type                  cmd_rd_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register writes
   always_comb begin
      out_planes_in = out_planes_ff;
      in_planes_in  = in_planes_ff;
      orient_in     = orient_ff;
      kern_h_in     = kern_h_ff;
      kern_w_in     = kern_w_ff;
      rot_in        = rot_ff;
      if (csr_write) begin
         case (csr_index)
            rfs_pkg::REG_OUT_PLANES:    out_planes_in = csr_wdata;
            rfs_pkg::REG_IN_PLANES:     in_planes_in  = csr_wdata;
            rfs_pkg::REG_ORIENTATIONS:  orient_in     = csr_wdata[rfs_pkg::CFG_ORIENT_W-1:0];
            rfs_pkg::REG_KERNEL_HEIGHT: kern_h_in     = csr_wdata[rfs_pkg::CFG_KERNEL_W-1:0];
            rfs_pkg::REG_KERNEL_WIDTH:  kern_w_in     = csr_wdata[rfs_pkg::CFG_KERNEL_W-1:0];
            rfs_pkg::REG_ROTATIONS:     rot_in        = csr_wdata[rfs_pkg::CFG_ROT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_planes_ff <= rfs_pkg::CFG_PLANE_W'(1);
         in_planes_ff  <= rfs_pkg::CFG_PLANE_W'(1);
         orient_ff     <= rfs_pkg::CFG_ORIENT_W'(1);
         kern_h_ff     <= rfs_pkg::CFG_KERNEL_W'(1);
         kern_w_ff     <= rfs_pkg::CFG_KERNEL_W'(1);
         rot_ff        <= rfs_pkg::CFG_ROT_W'(1);
      end else begin
         out_planes_ff <= out_planes_in;
         in_planes_ff  <= in_planes_in;
         orient_ff     <= orient_in;
         kern_h_ff     <= kern_h_in;
         kern_w_ff     <= kern_w_in;
         rot_ff        <= rot_in;
      end
   end

   // effective configuration
   always_comb begin
      cfg.op  = rfs_pkg::clamp_planes(out_planes_ff);
      cfg.ip  = rfs_pkg::clamp_planes(in_planes_ff);
      cfg.rot = rfs_pkg::clamp_rot(rot_ff);
      cfg.ent = rfs_pkg::calc_entries(orient_ff, kern_h_ff, kern_w_ff);
   end

   rfs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_table_addr  (req_table_addr),
      .req_table_value (req_table_value),
      .req_weight_word (req_weight_word),
      .cfg             (cfg),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_wr_data),
      .cmd_full        (cmd_full)
   );

   rfs_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   rfs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_empty          (cmd_empty),
      .cmd_data           (cmd_rd_data),
      .cmd_pop            (cmd_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_target_address (rsp_target_address),
      .rsp_value_word     (rsp_value_word),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_bad_index      (rsp_bad_index),
      .rsp_last_of_bank   (rsp_last_of_bank)
   );

endmodule
`default_nettype wire
